[sv/srpd_pkg.sv]
// Shared types, constants and tables for the stepper ramp profile driver.
package srpd_pkg;

	localparam int RAMP_LEVELS   = 7;
	localparam int PHASE_COUNT   = 6;
	localparam int TABLE_LEVELS  = 7;
	localparam int PATTERN_COUNT = 6;

	localparam int LVL_W = (RAMP_LEVELS > 1) ? $clog2(RAMP_LEVELS) : 1;
	localparam int PH_W  = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
	localparam int TAB_W = $clog2(TABLE_LEVELS);

	localparam int CMD_W   = 2;
	localparam int POS_W   = 10;
	localparam int COIL_W  = 4;
	localparam int DLY_W   = 8;
	localparam int LSL_W   = 3;
	localparam int REG_W   = 2;
	localparam int CDATA_W = 10;

	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_TICK = 2'd0;
	localparam cmd_t CMD_MOVE = 2'd1;
	localparam cmd_t CMD_HOME = 2'd2;

	typedef logic [REG_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_DECEL_STEPS = 2'd0;
	localparam reg_idx_t REG_HOME_STEPS  = 2'd1;
	localparam reg_idx_t REG_HOME_DELAY  = 2'd2;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_MOVE = 2'd1,
		MODE_HOME = 2'd2
	} mode_t;

	typedef struct packed {
		logic [COIL_W-1:0] coils;
		logic              busy_res;
		logic [POS_W-1:0]  position;
	} res_t;

	// Clamp a ramp level onto the table.
	function automatic logic [TAB_W-1:0] tab_index(input logic [LVL_W-1:0] lvl);
		if (int'(lvl) < TABLE_LEVELS)
			return TAB_W'(lvl);
		return TAB_W'(TABLE_LEVELS - 1);
	endfunction

	function automatic logic [DLY_W-1:0] ramp_delay(input logic [TAB_W-1:0] idx);
		logic [10:0] us;
		case (idx)
			3'd0:    us = 11'd1750;
			3'd1:    us = 11'd1149;
			3'd2:    us = 11'd926;
			3'd3:    us = 11'd794;
			3'd4:    us = 11'd709;
			3'd5:    us = 11'd666;
			default: us = 11'd450;
		endcase
		return DLY_W'((us >> 4) + 11'd1);
	endfunction

	function automatic logic [LSL_W-1:0] ramp_len(input logic [TAB_W-1:0] idx);
		case (idx)
			3'd5, 3'd6: return LSL_W'(4);
			default:    return LSL_W'(3);
		endcase
	endfunction

	function automatic logic [COIL_W-1:0] coil_pat(input logic [PH_W-1:0] p);
		case (int'(p))
			0:       return 4'h9;
			1:       return 4'h1;
			2:       return 4'h7;
			3:       return 4'h6;
			4:       return 4'hE;
			5:       return 4'h8;
			default: return 4'h0;
		endcase
	endfunction

endpackage

[sv/srpd_if.sv]
// Request channels of the stepper ramp profile driver.
interface srpd_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [srpd_pkg::CMD_W-1:0]     cmd;
	logic [srpd_pkg::POS_W-1:0]     target;
	modport source (output valid, cmd, target, input ready);
	modport sink (input valid, cmd, target, output ready);
endinterface

interface srpd_res_if;
	logic                           valid;
	logic                           ready;
	logic [srpd_pkg::COIL_W-1:0]    coils;
	logic                           busy_res;
	logic [srpd_pkg::POS_W-1:0]     position;
	modport source (output valid, coils, busy_res, position, input ready);
	modport sink (input valid, coils, busy_res, position, output ready);
endinterface

interface srpd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [srpd_pkg::REG_W-1:0]     index;
	logic [srpd_pkg::CDATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/srpd_core.sv]
// Motion state, configuration registers and per-request next-state logic.
module srpd_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  srpd_pkg::reg_idx_t           cfg_index,
	input  logic [srpd_pkg::CDATA_W-1:0] cfg_data,
	input  logic                         item_we,
	input  srpd_pkg::cmd_t               cmd,
	input  logic [srpd_pkg::POS_W-1:0]   target,
	output srpd_pkg::res_t               res
);
	import srpd_pkg::*;

	logic [7:0]       decel_steps_q;
	logic [POS_W-1:0] home_steps_q;
	logic [7:0]       home_delay_q;

	logic [POS_W-1:0]  position_q, position_d;
	logic [PH_W-1:0]   phase_q, phase_d;
	logic [POS_W-1:0]  steps_left_q, steps_left_d;
	logic [LVL_W-1:0]  ramp_level_q, ramp_level_d;
	logic [LSL_W-1:0]  lsl_q, lsl_d;
	logic [DLY_W-1:0]  delay_q, delay_d;
	logic              dir_q, dir_d;
	mode_t             mode_q, mode_d;
	logic [COIL_W-1:0] coil_q, coil_d;

	logic [PH_W-1:0]   p_mod;
	logic [PH_W:0]     p_inc;
	logic [PH_W-1:0]   ph_fwd, ph_back;
	logic              do_move_step, do_home_step, do_finish;
	logic              drive_fwd;

	// Phase wrapped into range: it never reaches twice the phase count.
	always_comb begin
		if (int'(phase_q) >= PHASE_COUNT)
			p_mod = PH_W'(int'(phase_q) - PHASE_COUNT);
		else
			p_mod = phase_q;
		p_inc = {1'b0, p_mod} + 1'b1;
		ph_fwd = (int'(p_inc) == PHASE_COUNT) ? '0 : PH_W'(p_inc);
		ph_back = (p_mod == '0) ? PH_W'(PHASE_COUNT - 1) : p_mod - 1'b1;
	end

	always_comb begin
		position_d   = position_q;
		phase_d      = phase_q;
		steps_left_d = steps_left_q;
		ramp_level_d = ramp_level_q;
		lsl_d        = lsl_q;
		delay_d      = delay_q;
		dir_d        = dir_q;
		mode_d       = mode_q;
		coil_d       = coil_q;
		do_move_step = 1'b0;
		do_home_step = 1'b0;
		do_finish    = 1'b0;

		case (cmd)
			CMD_TICK: begin
				if (mode_q != MODE_IDLE) begin
					if (delay_q > DLY_W'(1)) begin
						delay_d = delay_q - 1'b1;
					end else begin
						delay_d = '0;
						steps_left_d = steps_left_q - 1'b1;
						if (mode_q == MODE_MOVE) begin
							if (lsl_q != '0)
								lsl_d = lsl_q - 1'b1;
							position_d = dir_q ? position_q + 1'b1 : position_q - 1'b1;
							if (steps_left_d != '0)
								do_move_step = 1'b1;
							else
								mode_d = MODE_IDLE;
						end else begin
							if (steps_left_d != '0)
								do_home_step = 1'b1;
							else
								do_finish = 1'b1;
						end
					end
				end
			end
			CMD_MOVE: begin
				if (mode_q == MODE_IDLE && target != position_q) begin
					dir_d = (position_q < target);
					steps_left_d = dir_d ? target - position_q : position_q - target;
					ramp_level_d = '0;
					lsl_d = '0;
					mode_d = MODE_MOVE;
					do_move_step = 1'b1;
				end
			end
			CMD_HOME: begin
				if (mode_q == MODE_IDLE) begin
					steps_left_d = home_steps_q;
					if (home_steps_q == '0) begin
						do_finish = 1'b1;
					end else begin
						mode_d = MODE_HOME;
						do_home_step = 1'b1;
					end
				end
			end
			default: ;
		endcase

		// Ramp: climb while far from target, fall inside the decel window.
		if (do_move_step) begin
			if (steps_left_d <= POS_W'(decel_steps_q)) begin
				if (lsl_d == '0) begin
					if (ramp_level_d != '0)
						ramp_level_d = ramp_level_d - 1'b1;
					lsl_d = ramp_len(tab_index(ramp_level_d));
				end
			end else if (lsl_d == '0 && int'(ramp_level_d) < RAMP_LEVELS - 1) begin
				ramp_level_d = ramp_level_d + 1'b1;
				lsl_d = ramp_len(tab_index(ramp_level_d));
			end
			delay_d = ramp_delay(tab_index(ramp_level_d));
		end

		if (do_home_step)
			delay_d = (home_delay_q == '0) ? DLY_W'(1) : home_delay_q;

		drive_fwd = do_move_step && dir_d;
		if (do_move_step || do_home_step) begin
			coil_d = (int'(p_mod) < PATTERN_COUNT) ? coil_pat(p_mod) : '0;
			phase_d = drive_fwd ? ph_fwd : ph_back;
		end

		if (do_finish) begin
			position_d   = '0;
			phase_d      = '0;
			coil_d       = '0;
			steps_left_d = '0;
			mode_d       = MODE_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decel_steps_q <= 8'd23;
			home_steps_q  <= POS_W'(945);
			home_delay_q  <= 8'd119;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DECEL_STEPS: decel_steps_q <= cfg_data[7:0];
				REG_HOME_STEPS:  home_steps_q  <= cfg_data[POS_W-1:0];
				REG_HOME_DELAY:  home_delay_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			phase_q      <= '0;
			steps_left_q <= '0;
			ramp_level_q <= '0;
			lsl_q        <= '0;
			delay_q      <= '0;
			dir_q        <= 1'b0;
			mode_q       <= MODE_IDLE;
			coil_q       <= '0;
		end else if (item_we) begin
			position_q   <= position_d;
			phase_q      <= phase_d;
			steps_left_q <= steps_left_d;
			ramp_level_q <= ramp_level_d;
			lsl_q        <= lsl_d;
			delay_q      <= delay_d;
			dir_q        <= dir_d;
			mode_q       <= mode_d;
			coil_q       <= coil_d;
		end
	end

	assign res.coils    = coil_d;
	assign res.busy_res = (mode_d != MODE_IDLE);
	assign res.position = position_d;

endmodule

[sv/stepper_ramp_profile_driver.sv]
// Stepper ramp profile driver: one command in, one coil/position result out.
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the motion state updates in a single pass.
// A result left waiting stalls the input; one taken in that cycle lets a request in.
// Reset (arst_n low): position, phase and ramp cleared, coils off, registers
// back to decel 23, home steps 945, home delay 119.
module stepper_ramp_profile_driver (
	input logic       clk,
	input logic       arst_n,
	srpd_cmd_if.sink  cmd_ch,
	srpd_res_if.source res_ch,
	srpd_cfg_if.sink  cfg_ch
);
	import srpd_pkg::*;

	logic accept;
	res_t res_d;
	res_t res_q;
	logic res_valid_q;

	// Take a request whenever the result register is empty or being drained.
	assign cmd_ch.ready = !res_valid_q || res_ch.ready;
	assign accept = cmd_ch.valid && cmd_ch.ready;
	assign cfg_ch.ready = 1'b1;

	srpd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_ch.valid && cfg_ch.ready),
		.cfg_index (cfg_ch.index),
		.cfg_data  (cfg_ch.data),
		.item_we   (accept),
		.cmd       (cmd_ch.cmd),
		.target    (cmd_ch.target),
		.res       (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (accept)
			res_valid_q <= 1'b1;
		else if (res_ch.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res_d;
	end

	assign res_ch.valid    = res_valid_q;
	assign res_ch.coils    = res_q.coils;
	assign res_ch.busy_res = res_q.busy_res;
	assign res_ch.position = res_q.position;

endmodule

[tb/tb_stepper_ramp_profile_driver.sv]
// Self-checking testbench for the stepper ramp profile driver, with a queue-fed request driver.
module tb_stepper_ramp_profile_driver;
	import srpd_pkg::*;

	localparam cmd_t CMD_UNUSED    = 2'd3;
	localparam int   HALF_PERIOD   = 5;
	localparam int   RESET_CYCLES  = 9;
	localparam int   IDLE_PCT      = 7;
	localparam int   HOLD_CYCLES   = 60;
	localparam int   SETTLE_CYCLES = 4;
	localparam int   RAND_BUDGET   = 500;
	localparam int   PHASES        = 5;
	localparam int   MAX_REPORTS   = 10;

	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		pos_t              pos;
		logic [PH_W-1:0]   phase;
		pos_t              left;
		logic [LVL_W-1:0]  level;
		logic [LSL_W-1:0]  level_left;
		logic [DLY_W-1:0]  wait_ticks;
		logic              fwd;
		mode_t             mode;
		logic [COIL_W-1:0] coil;
	} motor_t;

	typedef struct packed {
		logic [7:0] decel;
		pos_t       home_n;
		logic [7:0] home_dly;
	} motor_cfg_t;

	typedef struct packed {
		cmd_t cmd;
		pos_t target;
	} request_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	srpd_cmd_if cmd_ch();
	srpd_res_if res_ch();
	srpd_cfg_if cfg_ch();

	stepper_ramp_profile_driver u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch),
		.cfg_ch (cfg_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	motor_t     model_st;
	motor_cfg_t model_cfg;
	motor_t     plan_st;
	motor_cfg_t plan_cfg;
	request_t   pending_q[$];
	res_t       expected_q[$];
	int         err_count  = 0;
	int         live_items = 0;
	bit         cmd_fire   = 1'b0;
	bit         calm       = 1'b0;
	bit         hold_go    = 1'b0;
	int         hold_left  = 0;

	function automatic int step_us(int lvl);
		case (lvl)
			0:       return 1750;
			1:       return 1149;
			2:       return 926;
			3:       return 794;
			4:       return 709;
			5:       return 666;
			default: return 450;
		endcase
	endfunction

	function automatic logic [LSL_W-1:0] level_len(int lvl);
		return (lvl >= 5) ? LSL_W'(4) : LSL_W'(3);
	endfunction

	function automatic logic [COIL_W-1:0] coil_of(int p);
		case (p)
			0:       return 4'h9;
			1:       return 4'h1;
			2:       return 4'h7;
			3:       return 4'h6;
			4:       return 4'hE;
			5:       return 4'h8;
			default: return 4'h0;
		endcase
	endfunction

	// Drive the pattern of the current phase, then advance the phase either way.
	function automatic motor_t step_coil(motor_t s, logic fwd);
		int p;
		p = int'(s.phase) % PHASE_COUNT;
		s.coil = coil_of(p);
		if (fwd)
			s.phase = PH_W'((p + 1) % PHASE_COUNT);
		else
			s.phase = PH_W'((p + PHASE_COUNT - 1) % PHASE_COUNT);
		return s;
	endfunction

	function automatic motor_t move_step(motor_t s, motor_cfg_t c);
		if (s.left <= c.decel) begin
			if (s.level_left == 0) begin
				if (s.level != 0)
					s.level = s.level - 1'b1;
				s.level_left = level_len(int'(s.level));
			end
		end else if (s.level_left == 0 && int'(s.level) < RAMP_LEVELS - 1) begin
			s.level = s.level + 1'b1;
			s.level_left = level_len(int'(s.level));
		end
		s = step_coil(s, s.fwd);
		s.wait_ticks = DLY_W'(step_us(int'(s.level)) / 16 + 1);
		return s;
	endfunction

	function automatic motor_t home_step(motor_t s, motor_cfg_t c);
		s = step_coil(s, 1'b0);
		s.wait_ticks = (c.home_dly == 0) ? DLY_W'(1) : c.home_dly;
		return s;
	endfunction

	function automatic motor_t home_done(motor_t s);
		s.pos   = '0;
		s.phase = '0;
		s.coil  = '0;
		s.left  = '0;
		s.mode  = MODE_IDLE;
		return s;
	endfunction

	function automatic motor_t motor_next(motor_t s, motor_cfg_t c, cmd_t cmd, pos_t tgt);
		case (cmd)
			CMD_TICK: begin
				if (s.mode != MODE_IDLE) begin
					if (s.wait_ticks > 1) begin
						s.wait_ticks = s.wait_ticks - 1'b1;
					end else begin
						// Book the finished step, then issue the next one on this tick.
						s.wait_ticks = '0;
						s.left = s.left - 1'b1;
						if (s.mode == MODE_MOVE) begin
							if (s.level_left != 0)
								s.level_left = s.level_left - 1'b1;
							s.pos = s.fwd ? s.pos + 1'b1 : s.pos - 1'b1;
							if (s.left != 0)
								s = move_step(s, c);
							else
								s.mode = MODE_IDLE;
						end else if (s.left != 0) begin
							s = home_step(s, c);
						end else begin
							s = home_done(s);
						end
					end
				end
			end
			CMD_MOVE: begin
				if (s.mode == MODE_IDLE && tgt != s.pos) begin
					s.fwd = s.pos < tgt;
					s.left = s.fwd ? tgt - s.pos : s.pos - tgt;
					s.level = '0;
					s.level_left = '0;
					s.mode = MODE_MOVE;
					s = move_step(s, c);
				end
			end
			CMD_HOME: begin
				if (s.mode == MODE_IDLE) begin
					s.left = c.home_n;
					if (s.left == 0) begin
						s = home_done(s);
					end else begin
						s.mode = MODE_HOME;
						s = home_step(s, c);
					end
				end
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic flag_error(string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Predict on every accepted request, check every accepted result.
	always @(posedge clk) begin : monitor
		res_t want;
		if (!arst_n) begin
			cmd_fire = 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_q.size() == 0) begin
					flag_error($sformatf("result with nothing expected: coils %h busy %b pos %0d",
						res_ch.coils, res_ch.busy_res, res_ch.position));
				end else begin
					want = expected_q.pop_front();
					if (res_ch.coils !== want.coils)
						flag_error($sformatf("coils: expected %h, got %h",
							want.coils, res_ch.coils));
					if (res_ch.busy_res !== want.busy_res)
						flag_error($sformatf("busy_res: expected %b, got %b",
							want.busy_res, res_ch.busy_res));
					if (res_ch.position !== want.position)
						flag_error($sformatf("position: expected %0d, got %0d",
							want.position, res_ch.position));
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_DECEL_STEPS: model_cfg.decel    = cfg_ch.data[7:0];
					REG_HOME_STEPS:  model_cfg.home_n   = cfg_ch.data[POS_W-1:0];
					REG_HOME_DELAY:  model_cfg.home_dly = cfg_ch.data[7:0];
					default: ;
				endcase
			end
			cmd_fire = cmd_ch.valid && cmd_ch.ready;
			if (cmd_fire) begin
				model_st = motor_next(model_st, model_cfg, cmd_ch.cmd, cmd_ch.target);
				want.coils    = model_st.coil;
				want.busy_res = model_st.mode != MODE_IDLE;
				want.position = model_st.pos;
				expected_q.push_back(want);
			end
		end
	end

	always @(negedge clk) begin : driver
		request_t nxt;
		bit offer;
		if (arst_n && (!cmd_ch.valid || cmd_fire)) begin
			offer = pending_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT);
			if (offer) begin
				nxt = pending_q.pop_front();
				cmd_ch.cmd    <= nxt.cmd;
				cmd_ch.target <= nxt.target;
			end
			cmd_ch.valid <= offer;
		end
	end

	always @(negedge clk) begin : receiver
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	task automatic push_req(cmd_t c, pos_t t);
		request_t r;
		motor_t was;
		r.cmd = c;
		r.target = t;
		was = plan_st;
		pending_q.push_back(r);
		plan_st = motor_next(plan_st, plan_cfg, c, t);
		if (plan_st != was)
			live_items++;
	endtask

	// Requests the block must ignore in its present state.
	task automatic push_noise();
		int pick;
		pick = $urandom_range(2);
		if (plan_st.mode != MODE_IDLE) begin
			case (pick)
				0:       push_req(CMD_MOVE, POS_W'($urandom));
				1:       push_req(CMD_HOME, POS_W'($urandom));
				default: push_req(CMD_UNUSED, POS_W'($urandom));
			endcase
		end else begin
			case (pick)
				0:       push_req(CMD_TICK, POS_W'($urandom));
				1:       push_req(CMD_MOVE, plan_st.pos);
				default: push_req(CMD_UNUSED, POS_W'($urandom));
			endcase
		end
	endtask

	task automatic run_out();
		while (plan_st.mode != MODE_IDLE) begin
			if ($urandom_range(99) < 6)
				push_noise();
			else
				push_req(CMD_TICK, POS_W'($urandom));
		end
	endtask

	// Wait for the queues and both channels to drain, then return at a falling edge.
	task automatic settle();
		do
			@(posedge clk);
		while (pending_q.size() != 0 || cmd_ch.valid || expected_q.size() != 0 ||
		       res_ch.valid);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int val);
		settle();
		cfg_ch.index <= idx;
		cfg_ch.data  <= CDATA_W'(val);
		cfg_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		plan_cfg = model_cfg;
	endtask

	task automatic random_episode();
		int roll;
		int span;
		roll = $urandom_range(99);
		if (roll < 12) begin
			push_noise();
		end else if (roll < 30) begin
			push_req(CMD_HOME, POS_W'($urandom));
			run_out();
		end else begin
			span = ($urandom_range(99) < 10) ? $urandom_range(28, 5) : $urandom_range(4, 1);
			if ((($urandom_range(1) == 1) && int'(plan_st.pos) >= span) ||
			    int'(plan_st.pos) + span > 1023)
				push_req(CMD_MOVE, plan_st.pos - POS_W'(span));
			else
				push_req(CMD_MOVE, plan_st.pos + POS_W'(span));
			run_out();
		end
	endtask

	initial begin : stimulus
		int start;
		cmd_ch.valid  = 1'b0;
		cmd_ch.cmd    = CMD_TICK;
		cmd_ch.target = '0;
		res_ch.ready  = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = REG_DECEL_STEPS;
		cfg_ch.data   = '0;
		model_st = '0;
		plan_st  = '0;
		model_cfg.decel    = 8'd23;
		model_cfg.home_n   = 10'd945;
		model_cfg.home_dly = 8'd119;
		plan_cfg = model_cfg;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Ignored codes, idle tick, move onto the current position, then a one-step move.
		push_req(CMD_UNUSED, '1);
		push_req(CMD_TICK, '0);
		push_req(CMD_MOVE, '0);
		push_req(CMD_MOVE, POS_W'(1));
		push_req(CMD_MOVE, '1);
		push_req(CMD_HOME, 10'h2AA);
		push_req(CMD_UNUSED, 10'h155);
		run_out();

		write_reg(REG_DECEL_STEPS, 0);
		write_reg(REG_HOME_STEPS, 0);
		write_reg(REG_HOME_DELAY, 0);
		// Zero-length homing run: ends at once.
		push_req(CMD_HOME, '0);
		push_req(CMD_MOVE, POS_W'(3));
		push_req(CMD_HOME, '1);
		run_out();
		push_req(CMD_MOVE, POS_W'(1));
		run_out();
		write_reg(REG_HOME_STEPS, 4);
		push_req(CMD_HOME, '0);
		run_out();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_DECEL_STEPS, 255);
					write_reg(REG_HOME_STEPS, 1);
					write_reg(REG_HOME_DELAY, 255);
				end
				1: begin
					write_reg(REG_DECEL_STEPS, 0);
					write_reg(REG_HOME_STEPS, 6);
					write_reg(REG_HOME_DELAY, 0);
				end
				2: begin
					write_reg(REG_DECEL_STEPS, $urandom_range(12, 1));
					write_reg(REG_HOME_STEPS, $urandom_range(10, 1));
					write_reg(REG_HOME_DELAY, $urandom_range(5, 1));
				end
				3: begin
					write_reg(REG_DECEL_STEPS, 23);
					write_reg(REG_HOME_STEPS, 150);
					write_reg(REG_HOME_DELAY, 1);
				end
				default: begin
					write_reg(REG_DECEL_STEPS, $urandom_range(40, 0));
					write_reg(REG_HOME_STEPS, $urandom_range(16, 0));
					write_reg(REG_HOME_DELAY, $urandom_range(6, 0));
				end
			endcase
			@(posedge clk);
			calm = (ph == 1);
			start = live_items;
			if (ph == 2) begin
				// Hold results off while a move is queued, so the input stalls.
				push_req(CMD_MOVE, plan_st.pos + POS_W'(2));
				@(posedge clk);
				hold_go = 1'b1;
				run_out();
			end else if (ph == 3) begin
				push_req(CMD_HOME, POS_W'($urandom));
				run_out();
			end
			while (live_items - start < RAND_BUDGET / PHASES) begin
				if ($urandom_range(99) < 5)
					settle();
				random_episode();
			end
			@(posedge clk);
			calm = 1'b0;
		end

		settle();
		repeat (10) @(negedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
